/* src/nrfe_pkg.sv */
// Shared types and constants for the NMEA RMC field extractor.
`default_nettype none
package nrfe_pkg;

  // Byte constants
  localparam logic [7:0] CharTrigger = 8'h43;  // 'C'
  localparam logic [7:0] CharActive  = 8'h41;  // 'A'
  localparam logic [7:0] CharComma   = 8'h2C;  // ','

  localparam int unsigned CountW = 13;
  localparam logic [CountW-1:0] BytesMax     = 13'd8191;
  localparam logic [CountW-1:0] LimitDefault = 13'd4200;

  // Path lengths
  localparam logic [3:0] TimeLen    = 4'd6;
  localparam logic [3:0] DateLen    = 4'd6;
  localparam logic [3:0] DateBase   = 4'd6;
  localparam logic [3:0] M1SkipLen  = 4'd10;
  localparam logic [3:0] LatLen     = 4'd11;
  localparam logic [3:0] LonLen     = 4'd12;
  localparam logic [3:0] M0Commas   = 4'd7;
  localparam logic [3:0] M2Commas   = 4'd5;
  localparam logic [3:0] M3Commas   = 4'd8;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;
  localparam logic [CfgIdxW-1:0] CfgFieldMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgByteLimit = 2'd1;

  typedef enum logic [1:0] {
    MODE_STATUS_TIME_DATE = 2'd0,
    MODE_LATITUDE         = 2'd1,
    MODE_LONGITUDE        = 2'd2,
    MODE_TIME_DATE        = 2'd3
  } field_mode_e;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_REJECT  = 2'd1,
    KIND_TIMEOUT = 2'd2
  } result_kind_e;

  typedef enum logic [14:0] {
    PH_SEARCH    = 15'b000000000000001,
    PH_M0_SKIP1  = 15'b000000000000010,
    PH_M0_TIME   = 15'b000000000000100,
    PH_M0_SKIP2  = 15'b000000000001000,
    PH_M0_STATUS = 15'b000000000010000,
    PH_M0_COMMAS = 15'b000000000100000,
    PH_M0_DATE   = 15'b000000001000000,
    PH_M1_SKIP   = 15'b000000010000000,
    PH_M1_LAT    = 15'b000000100000000,
    PH_M2_COMMAS = 15'b000001000000000,
    PH_M2_LON    = 15'b000010000000000,
    PH_M3_SKIP   = 15'b000100000000000,
    PH_M3_TIME   = 15'b001000000000000,
    PH_M3_COMMAS = 15'b010000000000000,
    PH_M3_DATE   = 15'b100000000000000
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [3:0]        step;
    logic [3:0]        comma;
    logic [CountW-1:0] bytes;
  } parse_state_t;

  typedef struct packed {
    result_kind_e kind;
    logic [3:0]   position;
    logic [7:0]   char_value;
    logic         last;
  } result_t;

endpackage
`default_nettype wire

/* src/nrfe_if.sv */
// Handshake channel interfaces: byte input, result output, configuration write.
`default_nettype none

interface nrfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrfe_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] position;
  logic [7:0] char_value;
  logic       last;
  modport source (output valid, output kind, output position, output char_value,
                  output last, input ready);
  modport sink   (input valid, input kind, input position, input char_value,
                  input last, output ready);
endinterface

interface nrfe_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/nrfe_cfg_regs.sv */
// Configuration register file: field mode and search byte limit.
`default_nettype none
module nrfe_cfg_regs
  import nrfe_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_valid_i,
  input  wire logic [CfgIdxW-1:0]  wr_index_i,
  input  wire logic [CfgDataW-1:0] wr_data_i,
  output field_mode_e              field_mode_o,
  output logic [CountW-1:0]        byte_limit_o
);

  field_mode_e       field_mode_q;
  logic [CountW-1:0] byte_limit_q;

  // Writes to indexes past the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_mode_q <= MODE_STATUS_TIME_DATE;
      byte_limit_q <= LimitDefault;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        CfgFieldMode: field_mode_q <= field_mode_e'(wr_data_i[1:0]);
        CfgByteLimit: byte_limit_q <= wr_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign field_mode_o = field_mode_q;
  assign byte_limit_o = byte_limit_q;

endmodule
`default_nettype wire

/* src/nrfe_step.sv */
// Per-byte next-state and result logic of the sentence matcher.
`default_nettype none
module nrfe_step
  import nrfe_pkg::*;
(
  input  wire parse_state_t      state_i,
  input  wire logic [7:0]        byte_i,
  input  wire field_mode_e       field_mode_i,
  input  wire logic [CountW-1:0] byte_limit_i,
  output parse_state_t           state_o,
  output logic                   emit_o,
  output result_t                result_o
);

  logic [CountW-1:0] bytes_inc;
  logic [3:0]        step_inc;
  logic [3:0]        comma_inc;
  logic [3:0]        comma_need;
  phase_e            comma_next;

  assign bytes_inc = (state_i.bytes < BytesMax) ? state_i.bytes + CountW'(1) : state_i.bytes;
  assign step_inc  = state_i.step + 4'd1;
  assign comma_inc = state_i.comma + ((byte_i == CharComma) ? 4'd1 : 4'd0);

  // Comma target and follow-on phase for the comma-counting phases
  always_comb begin
    case (state_i.phase)
      PH_M0_COMMAS: begin comma_need = M0Commas; comma_next = PH_M0_DATE; end
      PH_M3_COMMAS: begin comma_need = M3Commas; comma_next = PH_M3_DATE; end
      default:      begin comma_need = M2Commas; comma_next = PH_M2_LON;  end
    endcase
  end

  always_comb begin
    state_o       = state_i;
    state_o.bytes = bytes_inc;
    emit_o        = 1'b0;
    result_o      = '{kind: KIND_CHAR, position: state_i.step, char_value: byte_i,
                      last: 1'b0};
    case (state_i.phase)
      PH_SEARCH: begin
        if (byte_i == CharTrigger) begin
          state_o.step  = '0;
          state_o.comma = '0;
          case (field_mode_i)
            MODE_STATUS_TIME_DATE: state_o.phase = PH_M0_SKIP1;
            MODE_LATITUDE:         state_o.phase = PH_M1_SKIP;
            MODE_LONGITUDE:        state_o.phase = PH_M2_COMMAS;
            default:               state_o.phase = PH_M3_SKIP;
          endcase
        end else if (bytes_inc >= byte_limit_i) begin
          // timeout: re-arm and report
          state_o  = '{phase: PH_SEARCH, step: '0, comma: '0, bytes: '0};
          emit_o   = 1'b1;
          result_o = '{kind: KIND_TIMEOUT, position: '0, char_value: '0, last: 1'b1};
        end
      end
      PH_M0_SKIP1: begin state_o.phase = PH_M0_TIME; state_o.step = '0; end
      PH_M3_SKIP:  begin state_o.phase = PH_M3_TIME; state_o.step = '0; end
      PH_M0_TIME, PH_M3_TIME: begin
        emit_o       = 1'b1;
        state_o.step = step_inc;
        if (step_inc >= TimeLen) begin
          state_o.phase = (state_i.phase == PH_M0_TIME) ? PH_M0_SKIP2 : PH_M3_COMMAS;
          state_o.step  = '0;
          state_o.comma = '0;
        end
      end
      PH_M0_SKIP2: state_o.phase = PH_M0_STATUS;
      PH_M0_STATUS: begin
        if (byte_i == CharActive) begin
          state_o.phase = PH_M0_COMMAS;
          state_o.comma = '0;
        end else begin
          // rejection keeps the byte count
          state_o.phase = PH_SEARCH;
          state_o.step  = '0;
          state_o.comma = '0;
          emit_o        = 1'b1;
          result_o      = '{kind: KIND_REJECT, position: '0, char_value: byte_i,
                            last: 1'b1};
        end
      end
      PH_M0_COMMAS, PH_M2_COMMAS, PH_M3_COMMAS: begin
        state_o.comma = comma_inc;
        if (comma_inc >= comma_need) begin
          state_o.phase = comma_next;
          state_o.step  = '0;
          state_o.comma = '0;
        end
      end
      PH_M0_DATE, PH_M3_DATE: begin
        emit_o            = 1'b1;
        result_o.position = DateBase + state_i.step;
        state_o.step      = step_inc;
        if (step_inc >= DateLen) begin
          state_o       = '{phase: PH_SEARCH, step: '0, comma: '0, bytes: '0};
          result_o.last = 1'b1;
        end
      end
      PH_M1_SKIP: begin
        state_o.step = step_inc;
        if (step_inc >= M1SkipLen) begin
          state_o.phase = PH_M1_LAT;
          state_o.step  = '0;
        end
      end
      PH_M1_LAT, PH_M2_LON: begin
        emit_o       = 1'b1;
        state_o.step = step_inc;
        if (step_inc >= ((state_i.phase == PH_M1_LAT) ? LatLen : LonLen)) begin
          state_o       = '{phase: PH_SEARCH, step: '0, comma: '0, bytes: '0};
          result_o.last = 1'b1;
        end
      end
      default: begin
        // illegal phase code: back to searching, no result
        state_o.phase = PH_SEARCH;
        state_o.step  = '0;
        state_o.comma = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/nmea_rmc_field_extractor.sv */
// Top level of the NMEA RMC field extractor: input stage, matcher state, result register.
//
// Usage:
//   byte_i carries one received NMEA byte per request; res_o returns extracted
//   characters, status rejections and search timeouts, at most one result per byte.
//   cfg_i writes field_mode (index 0) and byte_limit (index 1); other indexes are
//   ignored. cfg_i is always ready; write only while no byte is in flight.
// Timing:
//   A byte is captured in an input register; the matcher state and result are
//   updated when the byte leaves that register, and the result sits in an output register.
//   One byte per cycle is sustained while results are taken; the per-byte state
//   update feeds back from the state register into itself.
// Reset:
//   rst_ni clears both pipeline stages and puts the matcher in search with the
//   byte count at zero; field_mode resets to 0 and byte_limit to 4200.
// Stall:
//   While a result waits on res_o.ready the input stage holds its byte; byte_i.ready
//   drops only when both stages are occupied and the result is not taken.
`default_nettype none
module nmea_rmc_field_extractor
  import nrfe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  nrfe_byte_if.sink       byte_i,
  nrfe_result_if.source   res_o,
  nrfe_cfg_if.sink        cfg_i
);

  field_mode_e       field_mode;
  logic [CountW-1:0] byte_limit;

  logic         s1_valid_q;
  logic [7:0]   s1_byte_q;
  parse_state_t state_q;
  parse_state_t state_d;
  logic         emit;
  result_t      result_d;
  logic         out_valid_q;
  result_t      out_q;
  logic         advance;

  assign cfg_i.ready = 1'b1;

  nrfe_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_valid_i   (cfg_i.valid),
    .wr_index_i   (cfg_i.index),
    .wr_data_i    (cfg_i.data),
    .field_mode_o (field_mode),
    .byte_limit_o (byte_limit)
  );

  nrfe_step u_step (
    .state_i      (state_q),
    .byte_i       (s1_byte_q),
    .field_mode_i (field_mode),
    .byte_limit_i (byte_limit),
    .state_o      (state_d),
    .emit_o       (emit),
    .result_o     (result_d)
  );

  // Stage 1 moves on when the result slot is free or being emptied
  assign advance      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign byte_i.ready = !s1_valid_q || advance;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      s1_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      s1_byte_q <= byte_i.rx_byte;
    end
  end

  // Matcher state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_SEARCH, step: '0, comma: '0, bytes: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= result_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.kind       = out_q.kind;
  assign res_o.position   = out_q.position;
  assign res_o.char_value = out_q.char_value;
  assign res_o.last       = out_q.last;

  // A byte held in stage 1 under stall must not change
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_byte_q))
    else $error("stage 1 byte lost under stall");

  // Every closing result leaves the matcher searching
  a_last_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit && result_d.last |=> state_q.phase == PH_SEARCH)
    else $error("matcher not re-armed after closing result");

  // A timeout clears the byte count
  a_timeout_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit && result_d.kind == KIND_TIMEOUT |=> state_q.bytes == '0)
    else $error("byte count not cleared on timeout");

endmodule
`default_nettype wire
